/* rtl/core/qtrm_pkg.sv */
package qtrm_pkg;

    // component format: signed Q2.FRAC_W
    localparam int COMP_W = 32;
    localparam int FRAC_W = COMP_W - 2;

    // exact intermediate widths
    localparam int PROD_W = 2 * COMP_W;     // signed product of two components
    localparam int SUM_W  = PROD_W + 1;     // sum or difference of two products
    localparam int NUM_W  = PROD_W + 2;     // numerator, doubled cross term
    localparam int NORM_W = PROD_W + 1;     // squared norm, unsigned
    localparam int REM_W  = PROD_W + 2;     // division remainder, shifted

    // matrix elements, row-major
    localparam int N_ELEM = 9;
    localparam int M00 = 0;
    localparam int M01 = 1;
    localparam int M02 = 2;
    localparam int M10 = 3;
    localparam int M11 = 4;
    localparam int M12 = 5;
    localparam int M20 = 6;
    localparam int M21 = 7;
    localparam int M22 = 8;

    // start transfer edge to the edge that samples the result strobe
    localparam int PIPE_LAT = COMP_W + 6;

    typedef logic signed [COMP_W-1:0] t_comp;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic signed [NUM_W-1:0]  t_num;
    typedef logic        [NORM_W-1:0] t_norm;
    typedef logic        [REM_W-1:0]  t_rem;
    typedef logic        [COMP_W-1:0] t_quot;

    typedef struct packed {
        t_rem rem;
        logic qbit;
    } t_div_step;

    // +1.0 and -1.0 in Q2.FRAC_W
    localparam t_comp ONE_POS = t_comp'(1) <<< FRAC_W;
    localparam t_comp ONE_NEG = -ONE_POS;

    // one restoring division step: optional shift, compare, subtract
    function automatic t_div_step div_step(t_rem rem_in, t_norm norm, logic shift);
        t_rem      trial;
        t_rem      dvs;
        t_div_step res;
        trial = shift ? {rem_in[REM_W-2:0], 1'b0} : rem_in;
        dvs   = REM_W'(norm);
        if (trial >= dvs) begin
            res.rem  = trial - dvs;
            res.qbit = 1'b1;
        end else begin
            res.rem  = trial;
            res.qbit = 1'b0;
        end
        return res;
    endfunction

    // drop the guard bit with round half away from zero, clamp, apply sign
    function automatic t_comp round_sat(t_quot q, logic neg);
        logic [COMP_W-1:0] mag;
        logic [COMP_W-1:0] max_p;
        logic [COMP_W-1:0] max_n;
        mag   = {1'b0, q[COMP_W-1:1]} + {{(COMP_W-1){1'b0}}, q[0]};
        max_p = {1'b0, {(COMP_W-1){1'b1}}};
        max_n = {1'b1, {(COMP_W-1){1'b0}}};
        if (!neg) begin
            if (mag > max_p) begin
                mag = max_p;
            end
            return t_comp'(mag);
        end else begin
            if (mag > max_n) begin
                mag = max_n;
            end
            return t_comp'(~mag + {{(COMP_W-1){1'b0}}, 1'b1});
        end
    endfunction

endpackage

/* rtl/core/quaternion_to_rotation_matrix_unit.sv */
// Quaternion to 3x3 rotation matrix. Takes one quaternion (w, x, y, z) in signed Q2.30, of
// any length, and returns the nine elements of the rotation matrix of the normalized
// quaternion in signed Q2.30, each the exact quotient rounded to nearest (ties away from
// zero). A quaternion of all zeros returns all-zero elements with o_zero_norm set. The block
// is a straight pipeline that never stalls: busy stays low, a new quaternion may be started
// in every cycle, and each result is shown for one cycle with o_done high. The latency is set
// by the nine restoring dividers, which retire one quotient bit per stage over COMP_W stages;
// products, pair sums, norm and numerators, sign handling and output rounding take one stage
// each. The receiver cannot hold results off.
module quaternion_to_rotation_matrix_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  qtrm_pkg::t_comp        i_quat_w,
    input  qtrm_pkg::t_comp        i_quat_x,
    input  qtrm_pkg::t_comp        i_quat_y,
    input  qtrm_pkg::t_comp        i_quat_z,
    output logic                   o_done,
    output qtrm_pkg::t_comp        o_m00,
    output qtrm_pkg::t_comp        o_m01,
    output qtrm_pkg::t_comp        o_m02,
    output qtrm_pkg::t_comp        o_m10,
    output qtrm_pkg::t_comp        o_m11,
    output qtrm_pkg::t_comp        o_m12,
    output qtrm_pkg::t_comp        o_m20,
    output qtrm_pkg::t_comp        o_m21,
    output qtrm_pkg::t_comp        o_m22,
    output logic                   o_zero_norm
);

    localparam int CW = qtrm_pkg::COMP_W;
    localparam int NE = qtrm_pkg::N_ELEM;

    // valid bits, one per stage
    logic r_v_in;
    logic r_v_prod;
    logic r_v_sum;
    logic r_v_num;
    logic r_v_div [0:CW];
    logic r_done;

    // input stage
    qtrm_pkg::t_comp r_qw, r_qx, r_qy, r_qz;

    // product stage
    qtrm_pkg::t_prod r_ww, r_xx, r_yy, r_zz;
    qtrm_pkg::t_prod r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;

    // pair sum stage
    qtrm_pkg::t_sum r_s_wwxx, r_s_yyzz, r_s_wwyy, r_s_xxzz, r_s_wwzz, r_s_xxyy;
    qtrm_pkg::t_sum r_d_xy_m_wz, r_d_xy_p_wz, r_d_xz_p_wy, r_d_xz_m_wy;
    qtrm_pkg::t_sum r_d_yz_m_wx, r_d_yz_p_wx;

    // numerator and norm stage
    qtrm_pkg::t_norm r_norm;
    qtrm_pkg::t_num  r_num [0:NE-1];

    // divider stages, index 0 holds the sign-magnitude split
    qtrm_pkg::t_rem  r_drem  [0:CW][0:NE-1];
    qtrm_pkg::t_quot r_dquot [0:CW][0:NE-1];
    logic            r_dneg  [0:CW][0:NE-1];
    qtrm_pkg::t_norm r_dnorm [0:CW];
    logic            r_dzero [0:CW];

    // output stage
    qtrm_pkg::t_comp r_m [0:NE-1];
    logic            r_zero;

    qtrm_pkg::t_div_step n_step [0:CW-1][0:NE-1];

    // no back pressure anywhere in the pipeline
    assign busy = 1'b0;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_in   <= 1'b0;
            r_v_prod <= 1'b0;
            r_v_sum  <= 1'b0;
            r_v_num  <= 1'b0;
            for (int k = 0; k <= CW; k++) begin
                r_v_div[k] <= 1'b0;
            end
            r_done   <= 1'b0;
        end else begin
            r_v_in     <= start && !busy;
            r_v_prod   <= r_v_in;
            r_v_sum    <= r_v_prod;
            r_v_num    <= r_v_sum;
            r_v_div[0] <= r_v_num;
            for (int k = 0; k < CW; k++) begin
                r_v_div[k+1] <= r_v_div[k];
            end
            r_done     <= r_v_div[CW];
        end
    end

    // input register and the ten products
    always_ff @(posedge i_clk) begin
        r_qw <= i_quat_w;
        r_qx <= i_quat_x;
        r_qy <= i_quat_y;
        r_qz <= i_quat_z;
        r_ww <= qtrm_pkg::t_prod'(r_qw) * qtrm_pkg::t_prod'(r_qw);
        r_xx <= qtrm_pkg::t_prod'(r_qx) * qtrm_pkg::t_prod'(r_qx);
        r_yy <= qtrm_pkg::t_prod'(r_qy) * qtrm_pkg::t_prod'(r_qy);
        r_zz <= qtrm_pkg::t_prod'(r_qz) * qtrm_pkg::t_prod'(r_qz);
        r_xy <= qtrm_pkg::t_prod'(r_qx) * qtrm_pkg::t_prod'(r_qy);
        r_xz <= qtrm_pkg::t_prod'(r_qx) * qtrm_pkg::t_prod'(r_qz);
        r_yz <= qtrm_pkg::t_prod'(r_qy) * qtrm_pkg::t_prod'(r_qz);
        r_wx <= qtrm_pkg::t_prod'(r_qw) * qtrm_pkg::t_prod'(r_qx);
        r_wy <= qtrm_pkg::t_prod'(r_qw) * qtrm_pkg::t_prod'(r_qy);
        r_wz <= qtrm_pkg::t_prod'(r_qw) * qtrm_pkg::t_prod'(r_qz);
    end

    // pair sums of squares and cross terms
    always_ff @(posedge i_clk) begin
        r_s_wwxx    <= qtrm_pkg::t_sum'(r_ww) + qtrm_pkg::t_sum'(r_xx);
        r_s_yyzz    <= qtrm_pkg::t_sum'(r_yy) + qtrm_pkg::t_sum'(r_zz);
        r_s_wwyy    <= qtrm_pkg::t_sum'(r_ww) + qtrm_pkg::t_sum'(r_yy);
        r_s_xxzz    <= qtrm_pkg::t_sum'(r_xx) + qtrm_pkg::t_sum'(r_zz);
        r_s_wwzz    <= qtrm_pkg::t_sum'(r_ww) + qtrm_pkg::t_sum'(r_zz);
        r_s_xxyy    <= qtrm_pkg::t_sum'(r_xx) + qtrm_pkg::t_sum'(r_yy);
        r_d_xy_m_wz <= qtrm_pkg::t_sum'(r_xy) - qtrm_pkg::t_sum'(r_wz);
        r_d_xy_p_wz <= qtrm_pkg::t_sum'(r_xy) + qtrm_pkg::t_sum'(r_wz);
        r_d_xz_p_wy <= qtrm_pkg::t_sum'(r_xz) + qtrm_pkg::t_sum'(r_wy);
        r_d_xz_m_wy <= qtrm_pkg::t_sum'(r_xz) - qtrm_pkg::t_sum'(r_wy);
        r_d_yz_m_wx <= qtrm_pkg::t_sum'(r_yz) - qtrm_pkg::t_sum'(r_wx);
        r_d_yz_p_wx <= qtrm_pkg::t_sum'(r_yz) + qtrm_pkg::t_sum'(r_wx);
    end

    // squared norm and the nine numerators
    always_ff @(posedge i_clk) begin
        r_norm <= qtrm_pkg::t_norm'(r_s_wwxx) + qtrm_pkg::t_norm'(r_s_yyzz);
        r_num[qtrm_pkg::M00] <= qtrm_pkg::t_num'(r_s_wwxx) - qtrm_pkg::t_num'(r_s_yyzz);
        r_num[qtrm_pkg::M11] <= qtrm_pkg::t_num'(r_s_wwyy) - qtrm_pkg::t_num'(r_s_xxzz);
        r_num[qtrm_pkg::M22] <= qtrm_pkg::t_num'(r_s_wwzz) - qtrm_pkg::t_num'(r_s_xxyy);
        r_num[qtrm_pkg::M01] <= qtrm_pkg::t_num'(r_d_xy_m_wz) <<< 1;
        r_num[qtrm_pkg::M02] <= qtrm_pkg::t_num'(r_d_xz_p_wy) <<< 1;
        r_num[qtrm_pkg::M10] <= qtrm_pkg::t_num'(r_d_xy_p_wz) <<< 1;
        r_num[qtrm_pkg::M12] <= qtrm_pkg::t_num'(r_d_yz_m_wx) <<< 1;
        r_num[qtrm_pkg::M20] <= qtrm_pkg::t_num'(r_d_xz_m_wy) <<< 1;
        r_num[qtrm_pkg::M21] <= qtrm_pkg::t_num'(r_d_yz_p_wx) <<< 1;
    end

    // trial subtract for every divider stage and lane
    always_comb begin
        for (int k = 0; k < CW; k++) begin
            for (int i = 0; i < NE; i++) begin
                n_step[k][i] = qtrm_pkg::div_step(r_drem[k][i], r_dnorm[k], 1'(k != 0));
            end
        end
    end

    // sign split, then one quotient bit per stage
    always_ff @(posedge i_clk) begin
        r_dnorm[0] <= r_norm;
        r_dzero[0] <= (r_norm == '0);
        for (int i = 0; i < NE; i++) begin
            r_dneg[0][i]  <= r_num[i][qtrm_pkg::NUM_W-1];
            r_drem[0][i]  <= r_num[i][qtrm_pkg::NUM_W-1] ? qtrm_pkg::t_rem'(-r_num[i])
                                                           : qtrm_pkg::t_rem'(r_num[i]);
            r_dquot[0][i] <= '0;
        end
        for (int k = 0; k < CW; k++) begin
            r_dnorm[k+1] <= r_dnorm[k];
            r_dzero[k+1] <= r_dzero[k];
            for (int i = 0; i < NE; i++) begin
                r_dneg[k+1][i]  <= r_dneg[k][i];
                r_drem[k+1][i]  <= n_step[k][i].rem;
                r_dquot[k+1][i] <= {r_dquot[k][i][CW-2:0], n_step[k][i].qbit};
            end
        end
    end

    // rounding, clamp and zero-quaternion override
    always_ff @(posedge i_clk) begin
        r_zero <= r_dzero[CW];
        for (int i = 0; i < NE; i++) begin
            r_m[i] <= r_dzero[CW] ? '0 : qtrm_pkg::round_sat(r_dquot[CW][i], r_dneg[CW][i]);
        end
    end

    assign o_done      = r_done;
    assign o_zero_norm = r_zero;
    assign o_m00       = r_m[qtrm_pkg::M00];
    assign o_m01       = r_m[qtrm_pkg::M01];
    assign o_m02       = r_m[qtrm_pkg::M02];
    assign o_m10       = r_m[qtrm_pkg::M10];
    assign o_m11       = r_m[qtrm_pkg::M11];
    assign o_m12       = r_m[qtrm_pkg::M12];
    assign o_m20       = r_m[qtrm_pkg::M20];
    assign o_m21       = r_m[qtrm_pkg::M21];
    assign o_m22       = r_m[qtrm_pkg::M22];

    // a result strobe always traces back to a start transfer a fixed latency earlier
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, qtrm_pkg::PIPE_LAT))
        else $error("result strobe without a matching start transfer");

    // zero quaternion gives all-zero elements
    a_zero_elems: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_zero_norm) |-> (o_m00 == '0 && o_m01 == '0 && o_m02 == '0 &&
                                     o_m10 == '0 && o_m11 == '0 && o_m12 == '0 &&
                                     o_m20 == '0 && o_m21 == '0 && o_m22 == '0))
        else $error("zero quaternion produced nonzero elements");

    // diagonal of a rotation stays within plus or minus one
    a_diag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_m00 <= qtrm_pkg::ONE_POS && o_m00 >= qtrm_pkg::ONE_NEG &&
                    o_m11 <= qtrm_pkg::ONE_POS && o_m11 >= qtrm_pkg::ONE_NEG &&
                    o_m22 <= qtrm_pkg::ONE_POS && o_m22 >= qtrm_pkg::ONE_NEG))
        else $error("diagonal element outside unit range");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 6;
    localparam int RANDOM_ITEMS   = 850;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int WIDE           = 128;

    localparam qtrm_pkg::t_comp C_MIN   = {1'b1, {(qtrm_pkg::COMP_W-1){1'b0}}};
    localparam qtrm_pkg::t_comp C_MAX   = {1'b0, {(qtrm_pkg::COMP_W-1){1'b1}}};
    localparam qtrm_pkg::t_comp C_ONE_P = qtrm_pkg::ONE_POS;
    localparam qtrm_pkg::t_comp C_ONE_N = qtrm_pkg::ONE_NEG;

    typedef struct packed {
        qtrm_pkg::t_comp [qtrm_pkg::N_ELEM-1:0] elem;
        logic                                   zero_norm;
    } t_mat;

    // one directed quaternion; typed rows carry a diagonal-only expected matrix
    typedef struct {
        qtrm_pkg::t_comp w;
        qtrm_pkg::t_comp x;
        qtrm_pkg::t_comp y;
        qtrm_pkg::t_comp z;
        bit              typed;
        qtrm_pkg::t_comp d0;
        qtrm_pkg::t_comp d1;
        qtrm_pkg::t_comp d2;
        logic            zn;
    } t_quat_row;

    typedef enum int {
        K_FULL,
        K_UNIT,
        K_SMALL,
        K_EDGE,
        K_ZERO
    } t_comp_kind;

    logic            i_clk;
    logic            i_rst_n;
    logic            start;
    logic            busy;
    qtrm_pkg::t_comp i_quat_w;
    qtrm_pkg::t_comp i_quat_x;
    qtrm_pkg::t_comp i_quat_y;
    qtrm_pkg::t_comp i_quat_z;
    logic            o_done;
    qtrm_pkg::t_comp o_m00;
    qtrm_pkg::t_comp o_m01;
    qtrm_pkg::t_comp o_m02;
    qtrm_pkg::t_comp o_m10;
    qtrm_pkg::t_comp o_m11;
    qtrm_pkg::t_comp o_m12;
    qtrm_pkg::t_comp o_m20;
    qtrm_pkg::t_comp o_m21;
    qtrm_pkg::t_comp o_m22;
    logic            o_zero_norm;

    t_mat pending_matrices [$];
    int   mismatches;
    int   sent_count;
    int   directed_count;
    int   checked_count;
    int   zero_norm_count;
    int   idle_cycles;
    int   burst_left;

    string elem_names [qtrm_pkg::N_ELEM] = '{"m00", "m01", "m02", "m10", "m11", "m12",
                                             "m20", "m21", "m22"};

    // directed quaternions: zero, pure axes at the extremes, most negative parts, mixed and tiny values
    t_quat_row directed_rows [22] = '{
        '{0, 0, 0, 0, 1'b1, 0, 0, 0, 1'b1},
        '{C_ONE_P, 0, 0, 0, 1'b1, C_ONE_P, C_ONE_P, C_ONE_P, 1'b0},
        '{C_ONE_N, 0, 0, 0, 1'b1, C_ONE_P, C_ONE_P, C_ONE_P, 1'b0},
        '{C_MIN, 0, 0, 0, 1'b1, C_ONE_P, C_ONE_P, C_ONE_P, 1'b0},
        '{1, 0, 0, 0, 1'b1, C_ONE_P, C_ONE_P, C_ONE_P, 1'b0},
        '{0, C_ONE_P, 0, 0, 1'b1, C_ONE_P, C_ONE_N, C_ONE_N, 1'b0},
        '{0, C_MAX, 0, 0, 1'b1, C_ONE_P, C_ONE_N, C_ONE_N, 1'b0},
        '{0, -1, 0, 0, 1'b1, C_ONE_P, C_ONE_N, C_ONE_N, 1'b0},
        '{0, 0, C_ONE_P, 0, 1'b1, C_ONE_N, C_ONE_P, C_ONE_N, 1'b0},
        '{0, 0, C_MIN, 0, 1'b1, C_ONE_N, C_ONE_P, C_ONE_N, 1'b0},
        '{0, 0, 0, C_ONE_N, 1'b1, C_ONE_N, C_ONE_N, C_ONE_P, 1'b0},
        '{0, 0, 0, C_MAX, 1'b1, C_ONE_N, C_ONE_N, C_ONE_P, 1'b0},
        '{C_MIN, C_MIN, C_MIN, C_MIN, 1'b0, 0, 0, 0, 1'b0},
        '{C_MAX, C_MAX, C_MAX, C_MAX, 1'b0, 0, 0, 0, 1'b0},
        '{C_MAX, C_MIN, C_MAX, C_MIN, 1'b0, 0, 0, 0, 1'b0},
        '{C_ONE_P, C_ONE_P, 0, 0, 1'b0, 0, 0, 0, 1'b0},
        '{32'sh2000_0000, 32'sh2000_0000, 32'sh2000_0000, 32'sh2000_0000,
          1'b0, 0, 0, 0, 1'b0},
        '{3, 1, 1, 1, 1'b0, 0, 0, 0, 1'b0},
        '{1, 1, 0, 0, 1'b0, 0, 0, 0, 1'b0},
        '{C_MIN, 1, -1, C_MAX, 1'b0, 0, 0, 0, 1'b0},
        '{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh3333_3333, 32'shCCCC_CCCC,
          1'b0, 0, 0, 0, 1'b0},
        '{-1, -1, -1, -1, 1'b0, 0, 0, 0, 1'b0}
    };

    quaternion_to_rotation_matrix_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_quat_w   (i_quat_w),
        .i_quat_x   (i_quat_x),
        .i_quat_y   (i_quat_y),
        .i_quat_z   (i_quat_z),
        .o_done     (o_done),
        .o_m00      (o_m00),
        .o_m01      (o_m01),
        .o_m02      (o_m02),
        .o_m10      (o_m10),
        .o_m11      (o_m11),
        .o_m12      (o_m12),
        .o_m20      (o_m20),
        .o_m21      (o_m21),
        .o_m22      (o_m22),
        .o_zero_norm(o_zero_norm)
    );

    // clock
    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // exact numer/norm in Q2.30, round half away from zero, clamp to range
    function automatic qtrm_pkg::t_comp rounded_quotient(logic signed [WIDE-1:0] numer,
                                                         logic [WIDE-1:0] norm);
        logic                       neg;
        logic [WIDE-1:0]            mag;
        logic [WIDE-1:0]            q;
        logic [qtrm_pkg::COMP_W-1:0] res;
        neg = numer < 0;
        mag = neg ? -numer : numer;
        q   = (mag << (qtrm_pkg::FRAC_W + 1)) / norm;
        q   = (q >> 1) + (q & 1);
        if (!neg && q > WIDE'(C_MAX)) begin
            q = WIDE'(C_MAX);
        end
        if (neg && q > (WIDE'(1) << (qtrm_pkg::COMP_W - 1))) begin
            q = WIDE'(1) << (qtrm_pkg::COMP_W - 1);
        end
        res = q[qtrm_pkg::COMP_W-1:0];
        return neg ? -res : res;
    endfunction

    // rotation matrix of the normalized quaternion, all sums exact
    function automatic t_mat rotation_matrix_of(qtrm_pkg::t_comp qw, qtrm_pkg::t_comp qx,
                                                qtrm_pkg::t_comp qy, qtrm_pkg::t_comp qz);
        logic signed [WIDE-1:0] w, x, y, z;
        logic signed [WIDE-1:0] ww, xx, yy, zz, norm;
        logic signed [WIDE-1:0] numer [qtrm_pkg::N_ELEM];
        t_mat m;
        w    = qw;
        x    = qx;
        y    = qy;
        z    = qz;
        ww   = w * w;
        xx   = x * x;
        yy   = y * y;
        zz   = z * z;
        norm = ww + xx + yy + zz;
        m    = '0;
        if (norm == 0) begin
            m.zero_norm = 1'b1;
            return m;
        end
        numer[qtrm_pkg::M00] = ww + xx - yy - zz;
        numer[qtrm_pkg::M01] = 2 * (x * y - w * z);
        numer[qtrm_pkg::M02] = 2 * (x * z + w * y);
        numer[qtrm_pkg::M10] = 2 * (x * y + w * z);
        numer[qtrm_pkg::M11] = ww + yy - xx - zz;
        numer[qtrm_pkg::M12] = 2 * (y * z - w * x);
        numer[qtrm_pkg::M20] = 2 * (x * z - w * y);
        numer[qtrm_pkg::M21] = 2 * (y * z + w * x);
        numer[qtrm_pkg::M22] = ww + zz - xx - yy;
        for (int e = 0; e < qtrm_pkg::N_ELEM; e++) begin
            m.elem[e] = rounded_quotient(numer[e], norm);
        end
        return m;
    endfunction

    function automatic qtrm_pkg::t_comp random_component(t_comp_kind kind);
        unique case (kind)
            K_FULL:  return qtrm_pkg::t_comp'($urandom);
            K_UNIT:  return qtrm_pkg::t_comp'($urandom_range(0, 32'h8000_0000)) - C_ONE_P;
            K_SMALL: return qtrm_pkg::t_comp'($urandom_range(0, 16)) - 8;
            K_EDGE: begin
                unique case ($urandom_range(0, 5))
                    0:       return C_MIN;
                    1:       return C_MAX;
                    2:       return C_ONE_P;
                    3:       return C_ONE_N;
                    4:       return 1;
                    default: return -1;
                endcase
            end
            default: return '0;
        endcase
    endfunction

    // sender pacing: bursts of random length, random gaps between them
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
    endtask

    // one start transfer; called at a rising edge, returns at the accepting edge
    task automatic transfer_quaternion(qtrm_pkg::t_comp w, qtrm_pkg::t_comp x,
                                       qtrm_pkg::t_comp y, qtrm_pkg::t_comp z, t_mat want);
        start    <= 1'b1;
        i_quat_w <= w;
        i_quat_x <= x;
        i_quat_y <= y;
        i_quat_z <= z;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        pending_matrices.push_back(want);
        sent_count++;
    endtask

    // hold off until every outstanding matrix has come back
    task automatic drain_matrices();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_matrices.size() != 0);
    endtask

    // result check against the oldest expected matrix, plus watchdog
    always @(posedge i_clk) begin
        t_mat got;
        t_mat want;
        if (i_rst_n === 1'b1) begin
            if ($isunknown(o_done)) begin
                $error("o_done unknown after reset");
                mismatches++;
            end
            if (o_done === 1'b1) begin
                got.elem[qtrm_pkg::M00] = o_m00;
                got.elem[qtrm_pkg::M01] = o_m01;
                got.elem[qtrm_pkg::M02] = o_m02;
                got.elem[qtrm_pkg::M10] = o_m10;
                got.elem[qtrm_pkg::M11] = o_m11;
                got.elem[qtrm_pkg::M12] = o_m12;
                got.elem[qtrm_pkg::M20] = o_m20;
                got.elem[qtrm_pkg::M21] = o_m21;
                got.elem[qtrm_pkg::M22] = o_m22;
                got.zero_norm = o_zero_norm;
                if (pending_matrices.size() == 0) begin
                    $error("matrix transfer with no quaternion outstanding");
                    mismatches++;
                end else begin
                    want = pending_matrices.pop_front();
                    for (int e = 0; e < qtrm_pkg::N_ELEM; e++) begin
                        if (got.elem[e] !== want.elem[e]) begin
                            $error("%s expected %0d actual %0d", elem_names[e],
                                   $signed(want.elem[e]), $signed(got.elem[e]));
                            mismatches++;
                        end
                    end
                    if (got.zero_norm !== want.zero_norm) begin
                        $error("zero_norm expected %0b actual %0b",
                               want.zero_norm, got.zero_norm);
                        mismatches++;
                    end
                    checked_count++;
                    if (want.zero_norm) begin
                        zero_norm_count++;
                    end
                end
                idle_cycles = 0;
            end else if (start === 1'b1 && busy === 1'b0) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL quaternion_to_rotation_matrix_unit");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        t_mat            want;
        qtrm_pkg::t_comp q [4];
        int              cls;
        t_comp_kind      kind;
        mismatches      = 0;
        sent_count      = 0;
        checked_count   = 0;
        zero_norm_count = 0;
        idle_cycles     = 0;
        burst_left      = 0;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_quat_w        = '0;
        i_quat_x        = '0;
        i_quat_y        = '0;
        i_quat_z        = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (directed_rows[r]) begin
            if (directed_rows[r].typed) begin
                want                     = '0;
                want.elem[qtrm_pkg::M00] = directed_rows[r].d0;
                want.elem[qtrm_pkg::M11] = directed_rows[r].d1;
                want.elem[qtrm_pkg::M22] = directed_rows[r].d2;
                want.zero_norm           = directed_rows[r].zn;
            end else begin
                want = rotation_matrix_of(directed_rows[r].w, directed_rows[r].x,
                                          directed_rows[r].y, directed_rows[r].z);
            end
            pace_sender();
            transfer_quaternion(directed_rows[r].w, directed_rows[r].x,
                                directed_rows[r].y, directed_rows[r].z, want);
        end
        directed_count = sent_count;
        drain_matrices();

        // random quaternions: zero, full range, near unit, tiny, mixed edge values
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            cls = $urandom_range(0, 19);
            for (int c = 0; c < 4; c++) begin
                if (cls == 0) begin
                    kind = K_ZERO;
                end else if (cls < 8) begin
                    kind = K_FULL;
                end else if (cls < 14) begin
                    kind = K_UNIT;
                end else if (cls < 16) begin
                    kind = K_SMALL;
                end else begin
                    kind = t_comp_kind'($urandom_range(K_FULL, K_ZERO));
                end
                q[c] = random_component(kind);
            end
            want = rotation_matrix_of(q[0], q[1], q[2], q[3]);
            pace_sender();
            transfer_quaternion(q[0], q[1], q[2], q[3], want);
            if (i == RANDOM_ITEMS / 2) begin
                drain_matrices();
            end
        end

        // wait out the pipeline, watching for stray results
        drain_matrices();
        repeat (qtrm_pkg::PIPE_LAT + 8) @(posedge i_clk);

        $display("%0d quaternions sent (%0d directed), %0d matrices checked",
                 sent_count, directed_count, checked_count);
        $display("%0d zero quaternions, %0d mismatches", zero_norm_count, mismatches);
        if (mismatches == 0) begin
            $display("PASS quaternion_to_rotation_matrix_unit");
        end else begin
            $display("FAIL quaternion_to_rotation_matrix_unit");
        end
        $finish;
    end

endmodule
